/* hw/rtl/wftq_pkg.sv */
// ----------------------------------------------------------------------------
// wftq_pkg
// Shared constants and types for the wheel force-feedback torque block.
// ----------------------------------------------------------------------------
package wftq_pkg;

    // Q8.12 fixed-point constants
    localparam logic [14:0] EPS_Q        = 15'd41;
    localparam logic [14:0] RAMP_BASE_Q  = 15'd819;
    localparam logic [15:0] ATTACK_LEN   = 16'd1;
    localparam logic [14:0] LEVEL_FULL   = 15'h7fff;
    localparam logic [12:0] WPOS_ONE     = 13'd4096;
    localparam int          Q_FRAC       = 12;

    // Shared divider geometry: quotient is saturated to DIV_Q_W bits
    localparam int DIV_NUM_W = 35;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_Q_W   = 17;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_AXIS_LOW     = 3'd0;
    localparam t_reg_idx REG_AXIS_HIGH    = 3'd1;
    localparam t_reg_idx REG_TORQUE_CAP   = 3'd2;
    localparam t_reg_idx REG_BRAKE_WINDOW = 3'd3;
    localparam t_reg_idx REG_BRAKE_RATIO  = 3'd4;
    localparam t_reg_idx REG_CTR_CAP      = 3'd5;
    localparam t_reg_idx REG_CTR_SPAN     = 3'd6;
    localparam t_reg_idx REG_AUTO_CENTER  = 3'd7;

    // Register reset values
    localparam logic [15:0] AXIS_LOW_RST     = 16'd0;
    localparam logic [15:0] AXIS_HIGH_RST    = 16'd65535;
    localparam logic [14:0] TORQUE_CAP_RST   = 15'd4096;
    localparam logic [14:0] BRAKE_WINDOW_RST = 15'd410;
    localparam logic [14:0] BRAKE_RATIO_RST  = 15'd819;
    localparam logic [14:0] CTR_CAP_RST      = 15'd1229;
    localparam logic [14:0] CTR_SPAN_RST     = 15'd819;
    localparam logic        AUTO_CENTER_RST  = 1'b1;

    // Item opcodes
    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

endpackage

/* hw/rtl/wftq_in_if.sv */
// ----------------------------------------------------------------------------
// wftq_in_if
// Input item channel: target updates and control ticks.
// ----------------------------------------------------------------------------
interface wftq_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [19:0] target_pos_in;
    logic signed [19:0] target_torque_in;
    logic        [15:0] axis_reading;
    logic               axis_fresh;

    modport source (
        output valid, opcode, target_pos_in, target_torque_in, axis_reading, axis_fresh,
        input  ready
    );
    modport sink (
        input  valid, opcode, target_pos_in, target_torque_in, axis_reading, axis_fresh,
        output ready
    );
endinterface

/* hw/rtl/wftq_out_if.sv */
// ----------------------------------------------------------------------------
// wftq_out_if
// Result item channel: force level, envelope, brake flag and wheel position.
// ----------------------------------------------------------------------------
interface wftq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] force_level;
    logic        [15:0] envelope_len;
    logic               braking;
    logic signed [13:0] wheel_pos_out;

    modport source (
        output valid, force_level, envelope_len, braking, wheel_pos_out,
        input  ready
    );
    modport sink (
        input  valid, force_level, envelope_len, braking, wheel_pos_out,
        output ready
    );
endinterface

/* hw/rtl/wftq_div.sv */
// ----------------------------------------------------------------------------
// wftq_div
// Iterative restoring divider, one quotient bit per cycle. The quotient is
// saturated to all ones when it would not fit in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module wftq_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wftq_pkg::DIV_NUM_W-1:0] i_dividend,
    input  logic [wftq_pkg::DIV_DEN_W-1:0] i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [wftq_pkg::DIV_Q_W-1:0]   o_quotient
);
    import wftq_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);
    localparam int PAD_W = DIV_NUM_W - DIV_Q_W - DIV_DEN_W;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_lo;

    logic                 ovf;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 take;
    logic [DIV_DEN_W-1:0] n_rem;

    // Quotient would exceed DIV_Q_W bits
    assign ovf = i_dividend[DIV_NUM_W-1:DIV_Q_W] >= {{PAD_W{1'b0}}, i_divisor};

    // One compare-subtract step
    always_comb begin
        trial = {r_rem, r_lo[DIV_Q_W-1]};
        diff  = trial - {1'b0, r_den};
        take  = trial >= {1'b0, r_den};
        n_rem = take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (ovf) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(DIV_Q_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= i_dividend[DIV_Q_W+DIV_DEN_W-1:DIV_Q_W];
            r_lo  <= ovf ? '1 : i_dividend[DIV_Q_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[DIV_Q_W-2:0], take};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_lo;

endmodule

/* hw/rtl/wheel_force_feedback_torque.sv */
// ----------------------------------------------------------------------------
// wheel_force_feedback_torque
// Turns the wheel position and a held target into a constant-force level.
// ----------------------------------------------------------------------------
// A target update is taken while idle and gives no result. A control tick
// makes its result item valid when the sequencer leaves its emit state: the
// path is set by one shared 17-step divider, used once to normalise a fresh
// axis reading and once more for the centering ramp, plus a single shared
// multiplier and a short sequencer. Braking adds the brake state, centering
// the divider start and wait states. No new item is taken while a tick is
// in work, nor while its result waits for the output register to free; a
// finished result waits in the output register while the next item is taken.
module wheel_force_feedback_torque (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wftq_in_if.sink                         i_in,
    wftq_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wftq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wftq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wftq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import wftq_pkg::*;

    localparam int TQ_W = 24;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_WAIT,
        S_DIST,
        S_MODE,
        S_CDIV,
        S_CWAIT,
        S_BRAKE,
        S_CLAMP,
        S_LEVEL,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [15:0] r_axis_low;
    logic [15:0] r_axis_high;
    logic [14:0] r_torque_cap;
    logic [14:0] r_brake_window;
    logic [14:0] r_brake_ratio;
    logic [14:0] r_ctr_cap;
    logic [14:0] r_ctr_span;
    logic        r_auto_center;

    // Architectural state
    logic [19:0] r_hold_pos;
    logic [18:0] r_hold_torque;
    logic [13:0] r_wheel_pos;
    logic        r_brake;

    // Working registers
    logic            r_nneg;
    logic [19:0]     r_dist;
    logic            r_dir;
    logic [DIV_NUM_W-1:0] r_prod;
    logic            r_psign;
    logic [TQ_W-1:0] r_torque;
    logic [15:0]     r_env;

    // Output register
    logic        r_ovalid;
    logic [15:0] r_o_level;
    logic [15:0] r_o_env;
    logic        r_o_brake;
    logic [13:0] r_o_wpos;

    // Divider hookup
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_quot;

    logic        acc_in;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic        emit_go;

    // Target update
    logic [19:0] tq_abs;
    logic [18:0] tq_mag;
    logic        tgt_changed;

    // Normalisation
    logic        range_ok;
    logic [18:0] norm_num;
    logic [18:0] norm_abs;
    logic [12:0] norm_qc;
    logic [13:0] norm_wpos;

    // Distance and mode
    logic [20:0] dist_s;
    logic [20:0] dist_abs;
    logic        centering;
    logic        dead_band;
    logic        in_window;
    logic        span_ok;
    logic [19:0] dist_m_eps;
    logic [15:0] cmm;
    logic [14:0] cmm_mag;
    logic [19:0] mul_a;
    logic [14:0] mul_b;
    logic [34:0] mul_p;
    logic [TQ_W-1:0] cap_ctr_t;
    logic [TQ_W-1:0] ht_t;

    // Centering ramp
    logic [18:0] ramp_sq;
    logic [18:0] ramp_mag;
    logic [18:0] ramp_cap;
    logic [TQ_W-1:0] ramp_t;

    // Brake torque
    logic [TQ_W-1:0] brake_t;

    // Clamp and level
    logic [TQ_W-1:0] cap_t;
    logic [TQ_W-1:0] ncap_t;
    logic [TQ_W-1:0] clamp_t;
    logic [TQ_W-1:0] tabs;
    logic [14:0]     tmag;
    logic [29:0]     lvl_p;
    logic [17:0]     lvl_s;
    logic [14:0]     lvl_sat;
    logic [15:0]     lvl;

    assign acc_in  = i_in.valid & i_in.ready;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;

    assign i_in.ready = (r_state == S_IDLE);

    // Result moves to the output register once that is free
    assign emit_go = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);

    // Register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_AXIS_LOW:     prdata = {16'd0, r_axis_low};
            REG_AXIS_HIGH:    prdata = {16'd0, r_axis_high};
            REG_TORQUE_CAP:   prdata = {17'd0, r_torque_cap};
            REG_BRAKE_WINDOW: prdata = {17'd0, r_brake_window};
            REG_BRAKE_RATIO:  prdata = {17'd0, r_brake_ratio};
            REG_CTR_CAP:      prdata = {17'd0, r_ctr_cap};
            REG_CTR_SPAN:     prdata = {17'd0, r_ctr_span};
            REG_AUTO_CENTER:  prdata = {31'd0, r_auto_center};
        endcase
    end

    // Target update: magnitude of torque, saturated to 19 bits
    always_comb begin
        tq_abs      = i_in.target_torque_in[19] ? (20'd0 - i_in.target_torque_in)
                                                : i_in.target_torque_in;
        tq_mag      = tq_abs[19] ? '1 : tq_abs[18:0];
        tgt_changed = (i_in.target_pos_in != r_hold_pos) || (tq_mag != r_hold_torque);
    end

    // Normalisation numerator 2r - hi - lo, sign and magnitude
    always_comb begin
        range_ok = r_axis_high > r_axis_low;
        norm_num = {2'b00, i_in.axis_reading, 1'b0} - {3'b000, r_axis_high}
                   - {3'b000, r_axis_low};
        norm_abs = norm_num[18] ? (19'd0 - norm_num) : norm_num;
        norm_qc  = (div_quot > {4'd0, WPOS_ONE}) ? WPOS_ONE : div_quot[12:0];
        norm_wpos = r_nneg ? (14'd0 - {1'b0, norm_qc}) : {1'b0, norm_qc};
    end

    // Divider operand select
    always_comb begin
        div_start = 1'b0;
        if (r_state == S_IDLE) begin
            div_start = acc_in && (i_in.opcode == OP_TICK) && i_in.axis_fresh && range_ok;
        end else if (r_state == S_CDIV) begin
            div_start = 1'b1;
        end
        if (r_state == S_IDLE) begin
            div_dividend = {{(DIV_NUM_W-29){1'b0}}, norm_abs[16:0], 12'd0};
            div_divisor  = r_axis_high - r_axis_low;
        end else begin
            div_dividend = r_prod;
            div_divisor  = {1'b0, r_ctr_span - EPS_Q};
        end
    end

    wftq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Distance, mode decision and the shared multiplier
    always_comb begin
        dist_s     = {r_hold_pos[19], r_hold_pos} - {{7{r_wheel_pos[13]}}, r_wheel_pos};
        dist_abs   = dist_s[20] ? (21'd0 - dist_s) : dist_s;
        centering  = r_brake | r_auto_center;
        dead_band  = r_dist < {5'd0, EPS_Q};
        in_window  = r_dist < {5'd0, r_brake_window};
        span_ok    = r_ctr_span > EPS_Q;
        dist_m_eps = r_dist - {5'd0, EPS_Q};
        cmm        = {1'b0, r_ctr_cap} - {1'b0, RAMP_BASE_Q};
        cmm_mag    = cmm[15] ? (15'd0 - cmm[14:0]) : cmm[14:0];
        mul_a      = centering ? dist_m_eps : {1'b0, r_hold_torque};
        mul_b      = centering ? cmm_mag : r_brake_ratio;
        mul_p      = {15'd0, mul_a} * {20'd0, mul_b};
        cap_ctr_t  = r_dir ? {9'd0, r_ctr_cap} : (TQ_W'(0) - {9'd0, r_ctr_cap});
        ht_t       = r_dir ? {5'd0, r_hold_torque} : (TQ_W'(0) - {5'd0, r_hold_torque});
    end

    // Centering ramp from the divider quotient
    always_comb begin
        ramp_sq  = r_psign ? (19'd0 - {2'b00, div_quot}) : {2'b00, div_quot};
        ramp_mag = ramp_sq + {4'd0, RAMP_BASE_Q};
        ramp_cap = ($signed(ramp_mag) > $signed({4'd0, r_ctr_cap})) ? {4'd0, r_ctr_cap}
                                                                    : ramp_mag;
        ramp_t   = r_dir ? {{(TQ_W-19){ramp_cap[18]}}, ramp_cap}
                         : (TQ_W'(0) - {{(TQ_W-19){ramp_cap[18]}}, ramp_cap});
    end

    // Reversed brake torque
    always_comb begin
        brake_t = r_dir ? (TQ_W'(0) - {1'b0, r_prod[34:Q_FRAC]})
                        : {1'b0, r_prod[34:Q_FRAC]};
    end

    // Symmetric clamp, then level = torque * 32767 / 4096 saturated
    always_comb begin
        cap_t   = {9'd0, r_torque_cap};
        ncap_t  = TQ_W'(0) - cap_t;
        if ($signed(r_torque) > $signed(cap_t)) begin
            clamp_t = cap_t;
        end else if ($signed(r_torque) < $signed(ncap_t)) begin
            clamp_t = ncap_t;
        end else begin
            clamp_t = r_torque;
        end
        tabs    = r_torque[TQ_W-1] ? (TQ_W'(0) - r_torque) : r_torque;
        tmag    = tabs[14:0];
        lvl_p   = {tmag, 15'd0} - {15'd0, tmag};
        lvl_s   = lvl_p[29:Q_FRAC];
        lvl_sat = (lvl_s > {3'd0, LEVEL_FULL}) ? LEVEL_FULL : lvl_s[14:0];
        lvl     = r_torque[TQ_W-1] ? (16'd0 - {1'b0, lvl_sat}) : {1'b0, lvl_sat};
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ovalid       <= 1'b0;
            r_axis_low     <= AXIS_LOW_RST;
            r_axis_high    <= AXIS_HIGH_RST;
            r_torque_cap   <= TORQUE_CAP_RST;
            r_brake_window <= BRAKE_WINDOW_RST;
            r_brake_ratio  <= BRAKE_RATIO_RST;
            r_ctr_cap      <= CTR_CAP_RST;
            r_ctr_span     <= CTR_SPAN_RST;
            r_auto_center  <= AUTO_CENTER_RST;
            r_hold_pos     <= '0;
            r_hold_torque  <= '0;
            r_wheel_pos    <= '0;
            r_brake        <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_AXIS_LOW:     r_axis_low     <= pwdata[15:0];
                    REG_AXIS_HIGH:    r_axis_high    <= pwdata[15:0];
                    REG_TORQUE_CAP:   r_torque_cap   <= pwdata[14:0];
                    REG_BRAKE_WINDOW: r_brake_window <= pwdata[14:0];
                    REG_BRAKE_RATIO:  r_brake_ratio  <= pwdata[14:0];
                    REG_CTR_CAP:      r_ctr_cap      <= pwdata[14:0];
                    REG_CTR_SPAN:     r_ctr_span     <= pwdata[14:0];
                    REG_AUTO_CENTER:  r_auto_center  <= pwdata[0];
                endcase
            end

            // output valid: loaded by a finished tick, cleared when taken
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        if (i_in.opcode == OP_TARGET) begin
                            if (tgt_changed) begin
                                r_hold_pos    <= i_in.target_pos_in;
                                r_hold_torque <= tq_mag;
                                r_brake       <= 1'b0;
                            end
                        end else if (i_in.axis_fresh && range_ok) begin
                            r_nneg  <= norm_num[18];
                            r_state <= S_NORM_WAIT;
                        end else begin
                            if (i_in.axis_fresh) begin
                                r_wheel_pos <= '0;
                            end
                            r_state <= S_DIST;
                        end
                    end
                end
                S_NORM_WAIT: begin
                    if (div_done) begin
                        r_wheel_pos <= norm_wpos;
                        r_state     <= S_DIST;
                    end
                end
                S_DIST: begin
                    r_dist  <= dist_abs[19:0];
                    r_dir   <= !dist_s[20] && (dist_s != 21'd0);
                    r_state <= S_MODE;
                end
                S_MODE: begin
                    if (dead_band) begin
                        r_env    <= '0;
                        r_torque <= '0;
                        r_state  <= S_CLAMP;
                    end else if (centering) begin
                        r_env <= '0;
                        if (span_ok) begin
                            r_prod  <= mul_p;
                            r_psign <= cmm[15];
                            r_state <= S_CDIV;
                        end else begin
                            r_torque <= cap_ctr_t;
                            r_state  <= S_CLAMP;
                        end
                    end else if (in_window) begin
                        r_brake <= 1'b1;
                        r_prod  <= mul_p;
                        r_env   <= ATTACK_LEN;
                        r_state <= S_BRAKE;
                    end else begin
                        r_torque <= ht_t;
                        r_env    <= ATTACK_LEN;
                        r_state  <= S_CLAMP;
                    end
                end
                S_CDIV: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    if (div_done) begin
                        r_torque <= ramp_t;
                        r_state  <= S_CLAMP;
                    end
                end
                S_BRAKE: begin
                    r_torque <= brake_t;
                    r_state  <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_torque <= clamp_t;
                    r_state  <= S_LEVEL;
                end
                S_LEVEL: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // load once the output register is free
                    if (emit_go) begin
                        r_o_level <= lvl;
                        r_o_env   <= r_env;
                        r_o_brake <= r_brake;
                        r_o_wpos  <= r_wheel_pos;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.force_level   = r_o_level;
    assign o_out.envelope_len  = r_o_env;
    assign o_out.braking       = r_o_brake;
    assign o_out.wheel_pos_out = r_o_wpos;

`ifndef SYNTHESIS
    // normalised position never leaves [-1, 1]
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed(r_wheel_pos) <= $signed({1'b0, WPOS_ONE})) &&
        ($signed(r_wheel_pos) >= $signed(14'd0 - {1'b0, WPOS_ONE})))
        else $error("wheel position out of range");

    // the divider is only started when idle
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // clamped torque lies within the configured cap
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEVEL) |-> (($signed(r_torque) <= $signed(cap_t)) &&
                                  ($signed(r_torque) >= $signed(ncap_t))))
        else $error("torque beyond cap after clamp");

    // brake flag is only raised by the rotate-mode decision
    a_brake_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_brake) |-> ($past(r_state) == S_MODE))
        else $error("brake flag set outside mode decision");
`endif

endmodule

/* sim/wheel_force_feedback_torque_tb.sv */
// ----------------------------------------------------------------------------
// wheel_force_feedback_torque_tb
// Self-checking bench for the wheel force-feedback torque block.
// ----------------------------------------------------------------------------
// Target updates and control ticks go in over the item channel. Each accepted
// tick is run through a local torque predictor and the expected force item is
// queued, then matched field by field against the result channel. A short
// directed pass covers axis and target extremes, centring and rotate modes
// and the brake flag; register settings with extreme values then carry
// random traffic, with random stalls on both sides.
module wheel_force_feedback_torque_tb;
    import wftq_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int SETTLE_CYCLES  = 64;
    localparam int TIMEOUT_CYCLES = 200000;

    // Predictor constants as signed 64-bit values
    localparam longint EPS_DIST    = EPS_Q;
    localparam longint RAMP_BASE   = RAMP_BASE_Q;
    localparam longint ENV_LEN     = ATTACK_LEN;
    localparam longint LEVEL_MAX   = LEVEL_FULL;
    localparam longint ONE_POS     = WPOS_ONE;
    localparam longint TORQUE_SAT  = 524287;

    typedef struct {
        logic               opcode;
        logic signed [19:0] target_pos;
        logic signed [19:0] target_torque;
        logic        [15:0] axis_reading;
        logic               axis_fresh;
    } t_wheel_item;

    typedef struct {
        logic signed [15:0] force_level;
        logic        [15:0] envelope_len;
        logic               braking;
        logic signed [13:0] wheel_pos;
    } t_force_result;

    typedef struct {
        logic [15:0] axis_low;
        logic [15:0] axis_high;
        logic [14:0] torque_cap;
        logic [14:0] brake_window;
        logic [14:0] brake_ratio;
        logic [14:0] ctr_cap;
        logic [14:0] ctr_span;
        logic        auto_center;
    } t_torque_setup;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wftq_in_if  item_if ();
    wftq_out_if result_if ();

    wheel_force_feedback_torque dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_if),
        .o_out   (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and register shadow
    t_torque_setup cur_setup;
    longint        held_pos;
    longint        held_torque;
    longint        wheel_pos_q;
    bit            brake_latched;
    int            last_reading;

    t_force_result pending_forces[$];
    int            mismatches;
    int            results_checked;
    int            ticks_sent;
    int            updates_sent;
    int            setups_applied;
    bit            steady_flow;

    // Clock
    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Result side: random back-pressure unless the flow is held steady
    always @(posedge i_clk) begin
        result_if.ready <= steady_flow || ($urandom_range(0, 99) >= 6);
    end

    function automatic longint clamp_q(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_torque_setup reset_setup();
        t_torque_setup s;
        s.axis_low     = AXIS_LOW_RST;
        s.axis_high    = AXIS_HIGH_RST;
        s.torque_cap   = TORQUE_CAP_RST;
        s.brake_window = BRAKE_WINDOW_RST;
        s.brake_ratio  = BRAKE_RATIO_RST;
        s.ctr_cap      = CTR_CAP_RST;
        s.ctr_span     = CTR_SPAN_RST;
        s.auto_center  = AUTO_CENTER_RST;
        return s;
    endfunction

    // Centring torque: ramp from the base torque with distance, capped
    function automatic longint centring_torque(longint dist_q, longint dir);
        longint cap;
        longint span;
        longint mag;
        cap  = cur_setup.ctr_cap;
        span = cur_setup.ctr_span;
        if (dist_q < EPS_DIST)
            return 0;
        if (span <= EPS_DIST) begin
            mag = cap;
        end else begin
            mag = RAMP_BASE + ((dist_q - EPS_DIST) * (cap - RAMP_BASE)) / (span - EPS_DIST);
            if (mag > cap)
                mag = cap;
        end
        return mag * dir;
    endfunction

    // Advances the predicted state by one item; returns 1 when a result is due
    function automatic bit predict_torque_step(input t_wheel_item it,
                                               output t_force_result res);
        longint pos_t;
        longint mag_t;
        longint lo;
        longint hi;
        longint raw;
        longint dist_q;
        longint dir;
        longint torque;
        longint cap;
        longint level;
        longint env;

        res = '{default: '0};
        if (it.opcode == OP_TARGET) begin
            pos_t = it.target_pos;
            mag_t = it.target_torque;
            if (mag_t < 0)
                mag_t = -mag_t;
            if (mag_t > TORQUE_SAT)
                mag_t = TORQUE_SAT;
            if (pos_t != held_pos || mag_t != held_torque) begin
                held_pos      = pos_t;
                held_torque   = mag_t;
                brake_latched = 1'b0;
            end
            return 1'b0;
        end

        // Normalise a fresh reading, else keep the old position
        if (it.axis_fresh) begin
            lo  = cur_setup.axis_low;
            hi  = cur_setup.axis_high;
            raw = it.axis_reading;
            if (hi <= lo)
                wheel_pos_q = 0;
            else
                wheel_pos_q = clamp_q(((2 * raw - hi - lo) * ONE_POS) / (hi - lo),
                                      -ONE_POS, ONE_POS);
        end

        dist_q = held_pos - wheel_pos_q;
        dir    = (dist_q > 0) ? 1 : -1;
        if (dist_q < 0)
            dist_q = -dist_q;

        env = 0;
        if (brake_latched || cur_setup.auto_center) begin
            torque = centring_torque(dist_q, dir);
        end else if (dist_q < EPS_DIST) begin
            torque = 0;
        end else if (dist_q < longint'(cur_setup.brake_window)) begin
            brake_latched = 1'b1;
            torque = -((held_torque * longint'(cur_setup.brake_ratio)) / ONE_POS) * dir;
            env    = ENV_LEN;
        end else begin
            torque = held_torque * dir;
            env    = ENV_LEN;
        end

        cap    = cur_setup.torque_cap;
        torque = clamp_q(torque, -cap, cap);
        level  = clamp_q((torque * LEVEL_MAX) / ONE_POS, -LEVEL_MAX, LEVEL_MAX);

        res.force_level  = 16'(level);
        res.envelope_len = 16'(env);
        res.braking      = brake_latched;
        res.wheel_pos    = 14'(wheel_pos_q);
        return 1'b1;
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_force_result want;
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready) begin
            if (pending_forces.size() == 0) begin
                log_mismatch($sformatf("result with nothing pending, level %0d",
                                       result_if.force_level));
            end else begin
                want = pending_forces.pop_front();
                results_checked++;
                if (result_if.force_level !== want.force_level)
                    log_mismatch($sformatf("force_level expected %0d, got %0d",
                                           want.force_level, result_if.force_level));
                if (result_if.envelope_len !== want.envelope_len)
                    log_mismatch($sformatf("envelope_len expected %0d, got %0d",
                                           want.envelope_len, result_if.envelope_len));
                if (result_if.braking !== want.braking)
                    log_mismatch($sformatf("braking expected %0b, got %0b",
                                           want.braking, result_if.braking));
                if (result_if.wheel_pos_out !== want.wheel_pos)
                    log_mismatch($sformatf("wheel_pos_out expected %0d, got %0d",
                                           want.wheel_pos, result_if.wheel_pos_out));
            end
        end
    end

    // Sends one item, with an occasional gap first, and predicts its result
    task automatic send_item(input t_wheel_item it);
        t_force_result res;
        if (!steady_flow && $urandom_range(0, 99) < 6) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        item_if.valid            <= 1'b1;
        item_if.opcode           <= it.opcode;
        item_if.target_pos_in    <= it.target_pos;
        item_if.target_torque_in <= it.target_torque;
        item_if.axis_reading     <= it.axis_reading;
        item_if.axis_fresh       <= it.axis_fresh;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        if (predict_torque_step(it, res)) begin
            pending_forces.push_back(res);
            ticks_sent++;
        end else begin
            updates_sent++;
        end
    endtask

    // Stop sending, wait for every result, then let the block settle
    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (pending_forces.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // APB read: setup cycle, then access; the data is compared at completion
    task automatic read_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want)
            log_mismatch($sformatf("register %0d read %0h, expected %0h",
                                   idx, prdata, want));
    endtask

    task automatic apply_setup(input t_torque_setup s);
        drain_results();
        write_reg(REG_AXIS_LOW,     CFG_DATA_W'(s.axis_low));
        write_reg(REG_AXIS_HIGH,    CFG_DATA_W'(s.axis_high));
        write_reg(REG_TORQUE_CAP,   CFG_DATA_W'(s.torque_cap));
        write_reg(REG_BRAKE_WINDOW, CFG_DATA_W'(s.brake_window));
        write_reg(REG_BRAKE_RATIO,  CFG_DATA_W'(s.brake_ratio));
        write_reg(REG_CTR_CAP,      CFG_DATA_W'(s.ctr_cap));
        write_reg(REG_CTR_SPAN,     CFG_DATA_W'(s.ctr_span));
        write_reg(REG_AUTO_CENTER,  CFG_DATA_W'(s.auto_center));
        read_reg(REG_AXIS_HIGH,     CFG_DATA_W'(s.axis_high));
        read_reg(REG_AUTO_CENTER,   CFG_DATA_W'(s.auto_center));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur_setup = s;
        setups_applied++;
    endtask

    function automatic t_wheel_item tick_item(int unsigned reading, bit fresh);
        t_wheel_item it;
        it.opcode        = OP_TICK;
        it.target_pos    = 20'($urandom());
        it.target_torque = 20'($urandom());
        it.axis_reading  = 16'(reading);
        it.axis_fresh    = fresh;
        return it;
    endfunction

    function automatic t_wheel_item update_item(int pos, int torque);
        t_wheel_item it;
        it.opcode        = OP_TARGET;
        it.target_pos    = 20'(pos);
        it.target_torque = 20'(torque);
        it.axis_reading  = 16'($urandom());
        it.axis_fresh    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Random item: targets half the time near the wheel so braking and the dead band
    // are reached, readings drifting from the last one four times in ten
    function automatic t_wheel_item random_wheel_item();
        t_wheel_item it;
        int unsigned pick;
        int          near;
        it.opcode = ($urandom_range(0, 99) < 30) ? OP_TARGET : OP_TICK;

        pick = $urandom_range(0, 9);
        if (pick < 5)
            it.target_pos = 20'(wheel_pos_q + int'($urandom_range(0, 1200)) - 600);
        else if (pick < 7)
            it.target_pos = 20'(int'($urandom_range(0, 10000)) - 5000);
        else if (pick < 8)
            it.target_pos = 20'(held_pos);
        else
            it.target_pos = 20'($urandom());

        pick = $urandom_range(0, 9);
        if (pick < 4)
            it.target_torque = 20'($urandom());
        else if (pick < 8)
            it.target_torque = 20'(int'($urandom_range(0, 16000)) - 8000);
        else if (pick < 9)
            it.target_torque = 20'($urandom_range(0, 1) ? -524288 : 524287);
        else
            it.target_torque = 20'($urandom_range(0, 1) ? held_torque : -held_torque);

        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            last_reading = $urandom_range(0, 65535);
        end else if (pick < 9) begin
            near         = last_reading + int'($urandom_range(0, 600)) - 300;
            last_reading = int'(clamp_q(near, 0, 65535));
        end else begin
            last_reading = $urandom_range(0, 1) ? 65535 : 0;
        end
        it.axis_reading = 16'(last_reading);
        it.axis_fresh   = ($urandom_range(0, 99) < 85);
        return it;
    endfunction

    task automatic run_random_phase(input t_torque_setup s, input int n_items,
                                    input bit no_idle, input bit hold_midway);
        apply_setup(s);
        steady_flow = no_idle;
        for (int k = 0; k < n_items; k++) begin
            // Hold off the sender until the block has delivered everything
            if (hold_midway && k == n_items / 2) begin
                item_if.valid <= 1'b0;
                do @(posedge i_clk); while (pending_forces.size() != 0);
            end
            send_item(random_wheel_item());
        end
        steady_flow = 1'b0;
    endtask

    // Reset settings: every tick in centring mode
    task automatic test_centring_defaults();
        send_item(tick_item(0, 1'b1));
        send_item(tick_item(65535, 1'b1));
        send_item(tick_item(32767, 1'b1));
        send_item(tick_item(32768, 1'b1));
        send_item(tick_item(12345, 1'b0));
        send_item(update_item(524287, -524288));
        send_item(tick_item(0, 1'b1));
        send_item(update_item(-524288, 1000));
        send_item(tick_item(65535, 1'b1));
    endtask

    // Rotate mode: dead band, braking, latched centring, full torque
    task automatic test_rotate_and_brake();
        t_torque_setup s;
        s             = reset_setup();
        s.auto_center = 1'b0;
        apply_setup(s);
        send_item(update_item(0, 3000));
        send_item(tick_item(32768, 1'b1));
        send_item(tick_item(34368, 1'b1));
        send_item(tick_item(0, 1'b0));
        // same target keeps the brake flag, also with the sign of the torque flipped
        send_item(update_item(0, 3000));
        send_item(tick_item(0, 1'b0));
        send_item(update_item(0, -3000));
        send_item(tick_item(0, 1'b0));
        send_item(update_item(0, 3001));
        send_item(tick_item(65535, 1'b1));
        send_item(update_item(0, 524287));
        send_item(tick_item(0, 1'b0));
    endtask

    // Random traffic under a spread of register settings, extremes included
    task automatic test_register_settings();
        t_torque_setup s;

        s = reset_setup();
        run_random_phase(s, 50, 1'b1, 1'b0);

        s.auto_center = 1'b0;
        run_random_phase(s, 60, 1'b0, 1'b1);

        s.torque_cap   = 15'h7fff;
        s.brake_window = 15'h7fff;
        s.brake_ratio  = 15'h7fff;
        s.ctr_cap      = 15'h7fff;
        s.ctr_span     = 15'h7fff;
        run_random_phase(s, 50, 1'b0, 1'b0);

        s              = reset_setup();
        s.auto_center  = 1'b0;
        s.torque_cap   = '0;
        s.brake_window = '0;
        s.brake_ratio  = '0;
        run_random_phase(s, 40, 1'b0, 1'b0);

        // empty axis range, degenerate centring span
        s             = reset_setup();
        s.axis_low    = 16'd40000;
        s.axis_high   = 16'd40000;
        s.ctr_span    = '0;
        s.ctr_cap     = 15'h7fff;
        s.torque_cap  = 15'h7fff;
        run_random_phase(s, 40, 1'b0, 1'b0);

        s             = reset_setup();
        s.axis_low    = 16'hffff;
        s.axis_high   = '0;
        s.ctr_cap     = '0;
        s.ctr_span    = 15'h7fff;
        s.auto_center = 1'b0;
        run_random_phase(s, 40, 1'b0, 1'b0);

        // narrow axis range saturates the position; cap under the ramp start
        s             = reset_setup();
        s.axis_low    = 16'd30000;
        s.axis_high   = 16'd30001;
        s.ctr_cap     = 15'd100;
        s.ctr_span    = 15'd100;
        s.torque_cap  = 15'h7fff;
        s.auto_center = 1'b0;
        run_random_phase(s, 50, 1'b0, 1'b0);

        repeat (2) begin
            s.axis_low     = 16'($urandom_range(0, 65535));
            s.axis_high    = 16'($urandom_range(0, 65535));
            s.torque_cap   = 15'($urandom_range(0, 32767));
            s.brake_window = 15'($urandom_range(0, 32767));
            s.brake_ratio  = 15'($urandom_range(0, 32767));
            s.ctr_cap      = 15'($urandom_range(0, 32767));
            s.ctr_span     = 15'($urandom_range(0, 32767));
            s.auto_center  = 1'($urandom_range(0, 1));
            run_random_phase(s, 60, 1'b0, 1'b0);
        end
    endtask

    // Main sequence
    initial begin
        cur_setup     = reset_setup();
        held_pos      = 0;
        held_torque   = 0;
        wheel_pos_q   = 0;
        brake_latched = 1'b0;
        last_reading  = 32768;
        steady_flow   = 1'b0;

        i_rst_n                  <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        item_if.valid            <= 1'b0;
        item_if.opcode           <= OP_TARGET;
        item_if.target_pos_in    <= '0;
        item_if.target_torque_in <= '0;
        item_if.axis_reading     <= '0;
        item_if.axis_fresh       <= 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_centring_defaults();
        test_rotate_and_brake();
        test_register_settings();

        drain_results();
        $display("Run covered %0d ticks and %0d target updates under %0d register settings.",
                 ticks_sent, updates_sent, setups_applied);
        $display("%0d force items checked, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && pending_forces.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Watchdog expired with %0d results outstanding.", pending_forces.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wftq_pkg.sv
hw/rtl/wftq_in_if.sv
hw/rtl/wftq_out_if.sv
hw/rtl/wftq_div.sv
hw/rtl/wheel_force_feedback_torque.sv
sim/wheel_force_feedback_torque_tb.sv
